>>> sv/assert_macros.svh
// Assertion macros used by the decode stage of the bytecode length decoder RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SBLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbld assertion failed");
`define SBLD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sbld assertion failed");
`else
`define SBLD_ASSERT(lbl, clk, rstn, prop)
`define SBLD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/sbld_pkg.sv
// Types, codes and the opcode table of the bytecode length decoder.
// No dependencies.
`default_nettype none

package sbld_pkg;

  localparam logic [7:0]  OP_CLOSURE   = 8'h54;
  localparam logic [7:0]  OP_HI_MASK   = 8'hF0;
  localparam logic [7:0]  OP_LO_MASK   = 8'h0F;
  localparam logic [7:0]  KIND_MAX     = 8'd3;

  typedef enum logic [3:0] {
    PH_OP   = 4'd0,
    PH_W1   = 4'd1,
    PH_W2   = 4'd2,
    PH_KIND = 4'd3,
    PH_CAPW = 4'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STOP     = 3'd1,
    ST_BAD_OP   = 3'd2,
    ST_BAD_KIND = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    POP_FIXED   = 2'd0,
    POP_WORD    = 2'd1,
    POP_WORD_P1 = 2'd2
  } pop_src_t;

  typedef enum logic [1:0] {
    CL_VALID   = 2'd0,
    CL_STOP    = 2'd1,
    CL_INVALID = 2'd2
  } cls_res_t;

  typedef struct packed {
    cls_res_t   res;
    logic [1:0] words;
    logic [1:0] push;
    logic [1:0] pop;
    pop_src_t   pop_src;
  } op_info_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } in_item_t;

  // start_position sits in the low bits
  typedef struct packed {
    status_t     status;
    logic [31:0] pops;
    logic [1:0]  pushes;
    logic [33:0] length;
    logic [7:0]  opcode;
    logic [31:0] start_position;
  } result_t;

  function automatic op_info_t classify(input logic [7:0] x);
    op_info_t   r;
    logic [7:0] hx;
    logic [7:0] lx;
    logic [3:0] h;
    logic [3:0] l;
    hx = x & OP_HI_MASK;
    lx = x & OP_LO_MASK;
    h  = hx[7:4];
    l  = lx[3:0];
    r  = '{res: CL_VALID, words: 2'd0, push: 2'd0, pop: 2'd0, pop_src: POP_FIXED};
    unique case (h)
      4'h0: begin
        if (l < 4'd1 || l > 4'd13) r.res = CL_INVALID;
        else begin
          r.push = 2'd1;
          r.pop  = 2'd2;
        end
      end
      4'h1: begin
        unique case (l) inside
          4'd0, 4'd1: begin r.words = 2'd1; r.push = 2'd1; end
          4'd2: begin r.words = 2'd2; r.push = 2'd1; r.pop_src = POP_WORD; end
          4'd3, 4'd11: begin r.push = 2'd1; r.pop = 2'd2; end
          4'd4: ;
          4'd5: r.words = 2'd1;
          4'd6, 4'd7: begin r.push = 2'd1; r.pop = 2'd1; end
          4'd8: r.pop = 2'd1;
          4'd9: begin r.push = 2'd2; r.pop = 2'd1; end
          4'd10: begin r.push = 2'd2; r.pop = 2'd2; end
          default: r.res = CL_INVALID;
        endcase
      end
      4'h2, 4'h3, 4'h4: begin
        if (l > 4'd3) r.res = CL_INVALID;
        else begin
          r.words = 2'd1;
          r.push  = 2'd1;
          r.pop   = (h == 4'h4) ? 2'd1 : 2'd0;
        end
      end
      4'h5: begin
        unique case (l) inside
          4'd0, 4'd1: begin r.words = 2'd1; r.pop = 2'd1; end
          4'd2, 4'd3: r.words = 2'd2;
          4'd4: begin r.words = 2'd2; r.push = 2'd1; end
          4'd5: begin r.words = 2'd1; r.push = 2'd1; r.pop_src = POP_WORD_P1; end
          4'd6: begin r.words = 2'd2; r.push = 2'd1; r.pop_src = POP_WORD; end
          4'd7: begin r.words = 2'd2; r.push = 2'd1; r.pop = 2'd1; end
          4'd8: begin r.words = 2'd1; r.push = 2'd1; r.pop = 2'd1; end
          4'd9: begin r.words = 2'd2; r.pop = 2'd1; end
          4'd10: r.words = 2'd1;
          default: r.res = CL_INVALID;
        endcase
      end
      4'h6: begin
        if (l > 4'd6) r.res = CL_INVALID;
        else begin
          r.push = 2'd1;
          r.pop  = (l == 4'd0) ? 2'd2 : 2'd1;
        end
      end
      4'h7: begin
        unique case (l) inside
          4'd0: r.push = 2'd1;
          4'd1, 4'd2, 4'd3: begin r.push = 2'd1; r.pop = 2'd1; end
          4'd4: begin r.words = 2'd1; r.push = 2'd1; r.pop_src = POP_WORD; end
          default: r.res = CL_INVALID;
        endcase
      end
      4'hF: r.res = CL_STOP;
      default: r.res = CL_INVALID;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/sbld_in_stage.sv
// Input register of the bytecode length decoder.
// Depends on sbld_pkg.
`default_nettype none

module sbld_in_stage
  import sbld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          s1_valid,
  output in_item_t      s1_item,
  input  wire logic     s1_take
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     load;

  assign in_ready     = !s1_valid_r || s1_take;
  assign load         = in_valid && in_ready;
  assign s1_valid_nxt = load || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

>>> sv/sbld_decode.sv
// Decode state and result register of the bytecode length decoder.
// Depends on sbld_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbld_decode
  import sbld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s1_valid,
  input  wire in_item_t    s1_item,
  output logic             s1_take,
  input  wire logic [31:0] code_length,
  output logic             res_valid,
  output result_t          res_data,
  input  wire logic        res_ready
);

  logic [31:0] bpos_r,  bpos_nxt;
  logic [31:0] start_r, start_nxt;
  logic [7:0]  op_r,    op_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  wbi_r,   wbi_nxt;
  logic [31:0] acc_r,   acc_nxt;
  logic [30:0] caps_r,  caps_nxt;
  logic        halted_r, halted_nxt;
  logic [33:0] len_r,   len_nxt;

  logic        out_valid_r;
  result_t     out_data_r;

  logic        go;
  logic        emit;
  result_t     res;
  op_info_t    cur_info;
  op_info_t    new_info;

  assign s1_take  = !out_valid_r || res_ready;
  assign go       = s1_valid && s1_take;
  assign cur_info = classify(op_r);
  assign new_info = classify(s1_item.code_byte);

  always_comb begin
    logic [7:0]  b;
    logic [31:0] pos;
    logic        halted_e;
    phase_t      phase_e;
    logic [1:0]  wbi_e;
    logic [31:0] acc_e;
    logic [30:0] caps_e;
    logic [33:0] len_inc;
    logic [31:0] acc_new;
    logic [30:0] caps_dec;
    logic        fin;
    op_info_t    fin_info;
    logic [31:0] fin_start;
    logic [7:0]  fin_op;
    logic [33:0] fin_len;

    bpos_nxt   = bpos_r;
    start_nxt  = start_r;
    op_nxt     = op_r;
    phase_nxt  = phase_r;
    wbi_nxt    = wbi_r;
    acc_nxt    = acc_r;
    caps_nxt   = caps_r;
    halted_nxt = halted_r;
    len_nxt    = len_r;
    emit       = 1'b0;
    res        = '{status: ST_OK, pops: 32'd0, pushes: 2'd0, length: 34'd0,
                   opcode: 8'd0, start_position: 32'd0};
    b          = s1_item.code_byte;
    pos        = s1_item.restart ? 32'd0 : bpos_r;
    halted_e   = s1_item.restart ? 1'b0 : halted_r;
    phase_e    = s1_item.restart ? PH_OP : phase_r;
    wbi_e      = s1_item.restart ? 2'd0 : wbi_r;
    acc_e      = s1_item.restart ? 32'd0 : acc_r;
    caps_e     = s1_item.restart ? 31'd0 : caps_r;
    len_inc    = len_r + 34'd1;
    acc_new    = (wbi_e == 2'd0) ? {24'd0, b}
                                 : (acc_e | ({24'd0, b} << {wbi_e, 3'b000}));
    caps_dec   = caps_e - 31'd1;
    fin        = 1'b0;
    fin_info   = cur_info;
    fin_start  = start_r;
    fin_op     = op_r;
    fin_len    = len_inc;

    if (go) begin
      if (s1_item.restart) begin
        bpos_nxt   = 32'd0;
        halted_nxt = 1'b0;
        phase_nxt  = PH_OP;
        wbi_nxt    = 2'd0;
        acc_nxt    = 32'd0;
        caps_nxt   = 31'd0;
      end
      if (!halted_e) begin
        bpos_nxt = pos + 32'd1;
        unique case (phase_e)
          PH_W1, PH_W2, PH_CAPW: begin
            len_nxt = len_inc;
            acc_nxt = acc_new;
            if (wbi_e != 2'd3) begin
              wbi_nxt = wbi_e + 2'd1;
            end else begin
              wbi_nxt = 2'd0;
              if (phase_e == PH_W1) begin
                if (cur_info.words == 2'd2) phase_nxt = PH_W2;
                else fin = 1'b1;
              end else if (phase_e == PH_W2) begin
                if (op_r == OP_CLOSURE && acc_new != 32'd0 && !acc_new[31]) begin
                  caps_nxt  = acc_new[30:0];
                  phase_nxt = PH_KIND;
                end else begin
                  fin = 1'b1;
                end
              end else begin
                caps_nxt = caps_dec;
                if (caps_dec == 31'd0) fin = 1'b1;
                else phase_nxt = PH_KIND;
              end
            end
          end
          PH_KIND: begin
            len_nxt = len_inc;
            if (b > KIND_MAX) begin
              halted_nxt = 1'b1;
              phase_nxt  = PH_OP;
              emit       = 1'b1;
              res        = '{status: ST_BAD_KIND, pops: 32'd0, pushes: 2'd0,
                             length: len_inc, opcode: op_r, start_position: start_r};
            end else begin
              phase_nxt = PH_CAPW;
              wbi_nxt   = 2'd0;
            end
          end
          default: begin
            phase_nxt = PH_OP;
            if (pos >= code_length) begin
              halted_nxt = 1'b1;
              emit       = 1'b1;
              res        = '{status: ST_RANGE, pops: 32'd0, pushes: 2'd0,
                             length: 34'd0, opcode: 8'd0, start_position: pos};
            end else begin
              start_nxt = pos;
              op_nxt    = b;
              len_nxt   = 34'd1;
              wbi_nxt   = 2'd0;
              if (new_info.res != CL_VALID) begin
                halted_nxt = 1'b1;
                emit       = 1'b1;
                res        = '{status: (new_info.res == CL_STOP) ? ST_STOP : ST_BAD_OP,
                               pops: 32'd0, pushes: 2'd0, length: 34'd1,
                               opcode: b, start_position: pos};
              end else if (new_info.words == 2'd0) begin
                fin       = 1'b1;
                fin_info  = new_info;
                fin_start = pos;
                fin_op    = b;
                fin_len   = 34'd1;
              end else begin
                phase_nxt = PH_W1;
              end
            end
          end
        endcase
        if (fin) begin
          phase_nxt          = PH_OP;
          emit               = 1'b1;
          res.status         = ST_OK;
          res.start_position = fin_start;
          res.opcode         = fin_op;
          res.length         = fin_len;
          res.pushes         = fin_info.push;
          case (fin_info.pop_src)
            POP_WORD:    res.pops = acc_new;
            POP_WORD_P1: res.pops = acc_new + 32'd1;
            default:     res.pops = {30'd0, fin_info.pop};
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r      <= 32'd0;
      start_r     <= 32'd0;
      op_r        <= 8'd0;
      phase_r     <= PH_OP;
      wbi_r       <= 2'd0;
      acc_r       <= 32'd0;
      caps_r      <= 31'd0;
      halted_r    <= 1'b1;
      len_r       <= 34'd0;
      out_valid_r <= 1'b0;
    end else begin
      bpos_r   <= bpos_nxt;
      start_r  <= start_nxt;
      op_r     <= op_nxt;
      phase_r  <= phase_nxt;
      wbi_r    <= wbi_nxt;
      acc_r    <= acc_nxt;
      caps_r   <= caps_nxt;
      halted_r <= halted_nxt;
      len_r    <= len_nxt;
      if (s1_take) begin
        out_valid_r <= go && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_data_r <= res;
    end
  end

  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  `SBLD_ASSERT(a_err_halts, clk, rst_n, go && emit && (res.status != ST_OK) |=> halted_r)
  `SBLD_ASSERT(a_halt_idle_phase, clk, rst_n, halted_r |-> phase_r == PH_OP)
  `SBLD_ASSERT(a_wbi_in_word, clk, rst_n, (wbi_r != 2'd0) |-> (phase_r == PH_W1 || phase_r == PH_W2 || phase_r == PH_CAPW))
  `SBLD_ASSERT(a_caps_live, clk, rst_n, (phase_r == PH_KIND || phase_r == PH_CAPW) |-> caps_r != 31'd0)

endmodule

`default_nettype wire

>>> sv/stack_bytecode_length_decoder_unit.sv
// Top level of the stack bytecode length decoder: config register, port packing.
// Depends on sbld_pkg, sbld_in_stage and sbld_decode.
//
//   channel  dir  payload                                   handshake
//   in_      in   tdata: code_byte, tuser: restart          tvalid/tready
//   out_     out  tdata: start..status (112 bits)           tvalid/tready
//   cfg_     in   wr_data: code_length                      wr_en
//
// One byte item per cycle sustained unless out_tready stalls the result register; the
// byte that completes a report passes the input register, then the result register.
// in_tready follows out_tready combinationally through the result register.
// After reset the decoder is halted until a byte with restart set arrives.
// code_length resets to 0.
`default_nettype none

module stack_bytecode_length_decoder_unit
  import sbld_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,     // [7:0] code_byte
  input  wire logic [0:0]   in_tuser,     // [0] restart
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,    // [31:0] start_position, [39:32] opcode,
                                          // [73:40] length, [75:74] pushes,
                                          // [107:76] pops, [110:108] status, [111] 0
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);

  logic [31:0] code_length_r;
  in_item_t    in_item;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s1_take;
  result_t     res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= 32'd0;
    end else if (cfg_wr_en) begin
      code_length_r <= cfg_wr_data;
    end
  end

  assign in_item = '{code_byte: in_tdata, restart: in_tuser[0]};

  sbld_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  sbld_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .s1_take     (s1_take),
    .code_length (code_length_r),
    .res_valid   (out_tvalid),
    .res_data    (res_data),
    .res_ready   (out_tready)
  );

  assign out_tdata = {1'b0, res_data};

endmodule

`default_nettype wire

>>> test/length_decode_checker.sv
`timescale 1ns / 100ps
// Checker for the stack bytecode length decoder: follows code_length writes and input items,
// predicts each instruction report and compares it field by field with the result channel.
// Depends on sbld_pkg for the result layout, phases and status codes.

module length_decode_checker
  import sbld_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  output int           reports_outstanding,
  output int           mismatches
);

  typedef struct {
    status_t    cls;
    logic [1:0] words;
    logic [1:0] push;
    logic [1:0] pop;
    pop_src_t   src;
  } op_shape_t;

  logic [31:0] code_len;
  logic [31:0] next_pos;
  logic [31:0] instr_pos;
  logic [7:0]  instr_op;
  phase_t      phase;
  logic [1:0]  byte_idx;
  logic [31:0] word_acc;
  logic [30:0] caps_left;
  logic        halted;
  logic [33:0] instr_len;
  result_t     reports_due[$];

  initial mismatches = 0;

  function automatic op_shape_t op_shape(input logic [7:0] op);
    op_shape_t  s;
    logic [3:0] h;
    logic [3:0] l;
    h = op[7:4];
    l = op[3:0];
    s.cls = ST_OK;
    s.words = 2'd0;
    s.push = 2'd0;
    s.pop = 2'd0;
    s.src = POP_FIXED;
    case (h)
      4'h0: begin
        if (l == 4'd0 || l > 4'd13) s.cls = ST_BAD_OP;
        else begin s.push = 2'd1; s.pop = 2'd2; end
      end
      4'h1: begin
        case (l)
          4'd0, 4'd1: begin s.words = 2'd1; s.push = 2'd1; end
          4'd2: begin s.words = 2'd2; s.push = 2'd1; s.src = POP_WORD; end
          4'd3, 4'd11: begin s.push = 2'd1; s.pop = 2'd2; end
          4'd4: ;
          4'd5: s.words = 2'd1;
          4'd6, 4'd7: begin s.push = 2'd1; s.pop = 2'd1; end
          4'd8: s.pop = 2'd1;
          4'd9: begin s.push = 2'd2; s.pop = 2'd1; end
          4'd10: begin s.push = 2'd2; s.pop = 2'd2; end
          default: s.cls = ST_BAD_OP;
        endcase
      end
      4'h2, 4'h3, 4'h4: begin
        if (l > 4'd3) s.cls = ST_BAD_OP;
        else begin
          s.words = 2'd1;
          s.push = 2'd1;
          s.pop = (h == 4'h4) ? 2'd1 : 2'd0;
        end
      end
      4'h5: begin
        case (l)
          4'd0, 4'd1: begin s.words = 2'd1; s.pop = 2'd1; end
          4'd2, 4'd3: s.words = 2'd2;
          4'd4: begin s.words = 2'd2; s.push = 2'd1; end
          4'd5: begin s.words = 2'd1; s.push = 2'd1; s.src = POP_WORD_P1; end
          4'd6: begin s.words = 2'd2; s.push = 2'd1; s.src = POP_WORD; end
          4'd7: begin s.words = 2'd2; s.push = 2'd1; s.pop = 2'd1; end
          4'd8: begin s.words = 2'd1; s.push = 2'd1; s.pop = 2'd1; end
          4'd9: begin s.words = 2'd2; s.pop = 2'd1; end
          4'd10: s.words = 2'd1;
          default: s.cls = ST_BAD_OP;
        endcase
      end
      4'h6: begin
        if (l > 4'd6) s.cls = ST_BAD_OP;
        else begin s.push = 2'd1; s.pop = (l == 4'd0) ? 2'd2 : 2'd1; end
      end
      4'h7: begin
        case (l)
          4'd0: s.push = 2'd1;
          4'd1, 4'd2, 4'd3: begin s.push = 2'd1; s.pop = 2'd1; end
          4'd4: begin s.words = 2'd1; s.push = 2'd1; s.src = POP_WORD; end
          default: s.cls = ST_BAD_OP;
        endcase
      end
      4'hF: s.cls = ST_STOP;
      default: s.cls = ST_BAD_OP;
    endcase
    return s;
  endfunction

  task automatic queue_report(input logic [31:0] p, input logic [7:0] op,
                              input logic [33:0] len, input logic [1:0] push,
                              input logic [31:0] pops, input status_t st);
    result_t r;
    r.start_position = p;
    r.opcode = op;
    r.length = len;
    r.pushes = push;
    r.pops = pops;
    r.status = st;
    reports_due.push_back(r);
  endtask

  task automatic complete_instr();
    op_shape_t   s;
    logic [31:0] pops;
    s = op_shape(instr_op);
    case (s.src)
      POP_WORD: pops = word_acc;
      POP_WORD_P1: pops = word_acc + 32'd1;
      default: pops = {30'd0, s.pop};
    endcase
    phase = PH_OP;
    queue_report(instr_pos, instr_op, instr_len, s.push, pops, ST_OK);
  endtask

  task automatic take_byte(input logic [7:0] b, input logic rs);
    op_shape_t   s;
    logic [31:0] p;
    if (rs) begin
      next_pos = 32'd0;
      halted = 1'b0;
      phase = PH_OP;
      byte_idx = 2'd0;
      word_acc = 32'd0;
      caps_left = 31'd0;
    end
    if (halted) return;
    p = next_pos;
    next_pos = p + 32'd1;
    if (phase == PH_W1 || phase == PH_W2 || phase == PH_CAPW) begin
      instr_len = instr_len + 34'd1;
      if (byte_idx == 2'd0) word_acc = {24'd0, b};
      else word_acc = word_acc | ({24'd0, b} << (8 * byte_idx));
      if (byte_idx != 2'd3) begin
        byte_idx = byte_idx + 2'd1;
        return;
      end
      byte_idx = 2'd0;
      s = op_shape(instr_op);
      if (phase == PH_W1) begin
        if (s.words == 2'd2) phase = PH_W2;
        else complete_instr();
      end else if (phase == PH_W2) begin
        if (instr_op == OP_CLOSURE && word_acc >= 32'd1 && word_acc <= 32'h7FFF_FFFF) begin
          caps_left = word_acc[30:0];
          phase = PH_KIND;
        end else complete_instr();
      end else begin
        caps_left = caps_left - 31'd1;
        if (caps_left == 31'd0) complete_instr();
        else phase = PH_KIND;
      end
    end else if (phase == PH_KIND) begin
      instr_len = instr_len + 34'd1;
      if (b > KIND_MAX) begin
        halted = 1'b1;
        phase = PH_OP;
        queue_report(instr_pos, instr_op, instr_len, 2'd0, 32'd0, ST_BAD_KIND);
      end else begin
        phase = PH_CAPW;
        byte_idx = 2'd0;
      end
    end else begin
      phase = PH_OP;
      if (p >= code_len) begin
        halted = 1'b1;
        queue_report(p, 8'd0, 34'd0, 2'd0, 32'd0, ST_RANGE);
      end else begin
        instr_pos = p;
        instr_op = b;
        instr_len = 34'd1;
        byte_idx = 2'd0;
        s = op_shape(b);
        if (s.cls != ST_OK) begin
          halted = 1'b1;
          queue_report(p, b, 34'd1, 2'd0, 32'd0, s.cls);
        end else if (s.words == 2'd0) complete_instr();
        else phase = PH_W1;
      end
    end
  endtask

  task automatic check_report(input result_t got);
    result_t want;
    if (reports_due.size() == 0) begin
      $error("unexpected result: start_position %0h opcode %0h", got.start_position, got.opcode);
      mismatches++;
      return;
    end
    want = reports_due.pop_front();
    if (got.start_position !== want.start_position) begin
      $error("start_position: expected %0h, got %0h", want.start_position, got.start_position);
      mismatches++;
    end
    if (got.opcode !== want.opcode) begin
      $error("opcode: expected %0h, got %0h", want.opcode, got.opcode);
      mismatches++;
    end
    if (got.length !== want.length) begin
      $error("length: expected %0h, got %0h", want.length, got.length);
      mismatches++;
    end
    if (got.pushes !== want.pushes) begin
      $error("pushes: expected %0h, got %0h", want.pushes, got.pushes);
      mismatches++;
    end
    if (got.pops !== want.pops) begin
      $error("pops: expected %0h, got %0h", want.pops, got.pops);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0h, got %0h", want.status, got.status);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      code_len = 32'd0;
      next_pos = 32'd0;
      instr_pos = 32'd0;
      instr_op = 8'd0;
      phase = PH_OP;
      byte_idx = 2'd0;
      word_acc = 32'd0;
      caps_left = 31'd0;
      halted = 1'b1;
      instr_len = 34'd0;
      reports_due.delete();
    end else begin
      if (cfg_wr_en) code_len = cfg_wr_data;
      if (out_tvalid === 1'b1 && out_tready) check_report(out_tdata[110:0]);
      if (in_tvalid && in_tready === 1'b1) take_byte(in_tdata, in_tuser[0]);
    end
    reports_outstanding = reports_due.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Top of the length decoder testbench: clock, reset, byte stimulus, result-side stalls, verdict.
// Depends on sbld_pkg, length_decode_checker and stack_bytecode_length_decoder_unit.

module testbench;
  import sbld_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD = 300;

  localparam logic [7:0] OP_ADD = 8'h01;
  localparam logic [7:0] OP_CONST = 8'h10;
  localparam logic [7:0] OP_SEXP = 8'h12;
  localparam logic [7:0] OP_NOARG = 8'h14;
  localparam logic [7:0] OP_CALLC = 8'h55;
  localparam logic [7:0] OP_BAD = 8'h00;
  localparam logic [7:0] OP_STOP = 8'hF0;
  localparam logic [7:0] KIND_BOGUS = 8'hFF;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic         cfg_wr_en;
  logic [31:0]  cfg_wr_data;

  int reports_outstanding;
  int mismatches;
  int cycle_count;
  int items_sent;
  bit idle_in;
  bit idle_out;
  int idle_pct;
  bit hold_req;

  stack_bytecode_length_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  length_decode_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .reports_outstanding(reports_outstanding),
    .mismatches         (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off per hold_req toggle
  initial begin
    int  hold_left;
    bit  hold_ack;
    hold_left = 0;
    hold_ack = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_out && $urandom_range(0, 99) < idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while (idle_in && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 1'b0);
  endtask

  // sender waits for every pending report, then lets the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (reports_outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_code_length(input logic [31:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int operand_words(input logic [7:0] op);
    case (op[7:4])
      4'h1: begin
        case (op[3:0])
          4'h0, 4'h1, 4'h5: return 1;
          4'h2: return 2;
          default: return 0;
        endcase
      end
      4'h2, 4'h3, 4'h4: return (op[3:0] <= 4'h3) ? 1 : 0;
      4'h5: begin
        case (op[3:0])
          4'h0, 4'h1, 4'h5, 4'h8, 4'hA: return 1;
          4'h2, 4'h3, 4'h4, 4'h6, 4'h7, 4'h9: return 2;
          default: return 0;
        endcase
      end
      4'h7: return (op[3:0] == 4'h4) ? 1 : 0;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_valid_op();
    logic [3:0] h;
    logic [3:0] l;
    case ($urandom_range(0, 5))
      0: begin h = 4'h0; l = 4'($urandom_range(1, 13)); end
      1: begin h = 4'h1; l = 4'($urandom_range(0, 11)); end
      2: begin h = 4'($urandom_range(2, 4)); l = 4'($urandom_range(0, 3)); end
      3: begin h = 4'h5; l = 4'($urandom_range(0, 10)); end
      4: begin h = 4'h6; l = 4'($urandom_range(0, 6)); end
      default: begin h = 4'h7; l = 4'($urandom_range(0, 4)); end
    endcase
    return {h, l};
  endfunction

  task automatic send_instr(input logic rs);
    logic [7:0]  op;
    logic [7:0]  kind;
    logic [31:0] count;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 4) op = 8'($urandom_range(240, 255));
    else if (r < 9) op = 8'($urandom_range(0, 255));
    else if (r < 27) op = OP_CLOSURE;
    else op = pick_valid_op();
    send_byte(op, rs);
    if (op == OP_CLOSURE) begin
      send_word($urandom());
      case ($urandom_range(0, 7))
        0: count = 32'd0;
        1: count = 32'h8000_0000 | $urandom();
        default: count = $urandom_range(1, 3);
      endcase
      send_word(count);
      if (!count[31]) begin
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 99) < 6) kind = 8'($urandom_range(4, 255));
          else kind = 8'($urandom_range(0, 3));
          send_byte(kind, 1'b0);
          send_word($urandom());
        end
      end
    end else begin
      for (int i = 0; i < operand_words(op); i++) send_word($urandom());
    end
  endtask

  // a run of instructions from position zero, now and then a stray byte
  task automatic send_program();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_instr(i == 0);
      if ($urandom_range(0, 99) < 4) send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int          ph;
    int          target;
    bit          paused;
    logic [31:0] cl;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    idle_in = 1'b0;
    idle_out = 1'b0;
    idle_pct = 61;
    hold_req = 1'b0;
    items_sent = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_code_length(32'hFFFF_FFFF);
    send_byte(OP_ADD, 1'b0);
    send_byte(OP_ADD, 1'b1);
    send_byte(OP_CONST, 1'b0);
    send_word(32'hFFFF_FFFF);
    send_byte(OP_CALLC, 1'b0);
    send_word(32'hFFFF_FFFF);
    send_byte(OP_SEXP, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(OP_NOARG, 1'b1);
    send_byte(OP_BAD, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(OP_STOP, 1'b1);
    send_byte(OP_CLOSURE, 1'b1);
    send_word(32'd0);
    send_word(32'd1);
    send_byte(KIND_BOGUS, 1'b0);
    set_code_length(32'd0);
    send_byte(OP_ADD, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: cl = 32'hFFFF_FFFF;
        1: cl = $urandom_range(4, 40);
        2: cl = $urandom_range(40, 400);
        default: cl = $urandom();
      endcase
      set_code_length(cl);
      idle_in = (ph == 1 || ph == 3);
      idle_out = (ph >= 2);
      idle_pct = (ph == 3) ? 36 : 61;
      if (ph == 0) hold_req = !hold_req;
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        send_program();
        if (ph == 2 && !paused && items_sent > target - 60) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
